// File: hw/rtl/bblur_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// 3x3 edge-aware box blur. No dependencies.
package bblur_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int LEAD_W  = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
    localparam int IROW_W  = $clog2(HEIGHT_LIMIT + 1);
    localparam int CSUM_W  = $clog2(3 * 255 + 1);
    localparam int SUM_W   = $clog2(9 * 255 + 1);
    localparam int NUM_W   = $clog2(2 * 9 * 255 + 9 + 1);
    localparam int CNT_W   = 4;
    localparam int DEN_W   = 5;
    localparam int DIV_STEPS = NUM_W;
    localparam int DSTEP_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic process;
        logic sum_load;
        logic div_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic out_free;
    } t_ctl_sts;

endpackage

// File: hw/rtl/bblur_in_if.sv
// Input pixel channel of the box blur: valid/ready plus opcode and RGB.
// Depends on bblur_pkg.
interface bblur_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [bblur_pkg::CH_W-1:0]  in_red;
    logic [bblur_pkg::CH_W-1:0]  in_green;
    logic [bblur_pkg::CH_W-1:0]  in_blue;

    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

// File: hw/rtl/bblur_out_if.sv
// Result channel of the box blur: valid/ready plus blurred RGB and frame end.
// Depends on bblur_pkg.
interface bblur_out_if;
    logic                        valid;
    logic                        ready;
    logic [bblur_pkg::CH_W-1:0]  out_red;
    logic [bblur_pkg::CH_W-1:0]  out_green;
    logic [bblur_pkg::CH_W-1:0]  out_blue;
    logic                        end_of_frame;

    modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

// File: hw/rtl/box_blur_3x3_edge_aware.sv
// Streaming 3x3 box blur with edge-aware averaging over RGB pixels.
// Depends on bblur_pkg, bblur_in_if, bblur_out_if, bblur_ctrl, bblur_dp.
//
// Usage:
//   i_pix carries pixels in raster order (opcode 0) and drain ticks (opcode 1).
//   o_res carries one blurred pixel per result, end_of_frame on the last one.
//   Each output channel is the rounded-half-up mean of the in-frame pixels of
//   the 3x3 neighbourhood of the pixel one row and one column back.
//   frame_width (index 0) and frame_height (index 1) are written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle; a write restarts
//   the frame. After the last pixel, frame_width+1 drain ticks flush the rest;
//   drain ticks arriving earlier are taken and ignored.
// Sequence:
//   An early drain is taken and dropped while idle; an item with no result
//   passes accept and read. An item that yields a result passes accept, read,
//   column sum, 13 restoring divide steps shared by the three channels, output load.
//   The first result follows input pixel (1,1); results lag by width+1 items.
// Reset and stall:
//   Reset restores 640x480 and clears all frame state; line stores keep data.
//   A finished result sits in the output register; the next item is taken
//   while it waits and only its own output load waits for the transfer.
module box_blur_3x3_edge_aware (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bblur_in_if.sink                              i_pix,
    bblur_out_if.source                           o_res,
    input  logic                                  i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    bblur_pkg::t_ctl_cmd w_cmd;
    bblur_pkg::t_ctl_sts w_sts;
    logic                w_in_ready;

    bblur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bblur_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_pix.opcode),
        .i_red          (i_pix.in_red),
        .i_green        (i_pix.in_green),
        .i_blue         (i_pix.in_blue),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_out_red      (o_res.out_red),
        .o_out_green    (o_res.out_green),
        .o_out_blue     (o_res.out_blue),
        .o_end_of_frame (o_res.end_of_frame)
    );

    assign i_pix.ready = w_in_ready;

    // a transfer that is not dropped occupies the sequencer for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && !w_sts.drop) |=> !i_pix.ready)
        else $error("input taken again while an item is in flight");

    // a result appears only after the sequencer loads the output register
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.out_load))
        else $error("result valid without an output load");

    // the divider runs exactly its fixed number of steps
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sum_load |-> ##(bblur_pkg::DIV_STEPS) w_cmd.div_step ##1 !w_cmd.div_step)
        else $error("divide step count wrong");

    // the output register is never reloaded while a result is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && o_res.valid) |-> o_res.ready)
        else $error("held result overwritten");
endmodule

// File: hw/rtl/bblur_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bblur_ctrl.sv
// Sequencer of the box blur: accept, line store read, column sum, divide, output.
// Depends on bblur_pkg.
module bblur_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bblur_pkg::t_ctl_sts   i_sts,
    output bblur_pkg::t_ctl_cmd   o_cmd
);
    bblur_pkg::t_state r_state, n_state;
    logic [bblur_pkg::DSTEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            bblur_pkg::ST_IDLE: begin
                if (i_in_valid && !i_sts.drop) begin
                    n_state = bblur_pkg::ST_READ;
                end
            end
            bblur_pkg::ST_READ: begin
                n_state = i_sts.emit ? bblur_pkg::ST_SUM : bblur_pkg::ST_IDLE;
            end
            bblur_pkg::ST_SUM: begin
                n_state = bblur_pkg::ST_DIV;
                n_step  = '0;
            end
            bblur_pkg::ST_DIV: begin
                if (r_step == bblur_pkg::DSTEP_W'(bblur_pkg::DIV_STEPS - 1)) begin
                    n_state = bblur_pkg::ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            bblur_pkg::ST_DONE: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    n_state = bblur_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bblur_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            bblur_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid && !i_sts.drop;
            end
            bblur_pkg::ST_READ: begin
                o_cmd.process = 1'b1;
            end
            bblur_pkg::ST_SUM: begin
                o_cmd.sum_load = 1'b1;
            end
            bblur_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            bblur_pkg::ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bblur_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule

// File: hw/rtl/bblur_dp.sv
// Datapath of the box blur: line stores, window, frame counters, masked sums,
// shared restoring divider and output register. Depends on bblur_pkg, bblur_ram.
module bblur_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bblur_pkg::t_ctl_cmd                   i_cmd,
    output bblur_pkg::t_ctl_sts                   o_sts,
    input  logic                                  i_opcode,
    input  logic [bblur_pkg::CH_W-1:0]            i_red,
    input  logic [bblur_pkg::CH_W-1:0]            i_green,
    input  logic [bblur_pkg::CH_W-1:0]            i_blue,
    input  logic                                  i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [bblur_pkg::CH_W-1:0]            o_out_red,
    output logic [bblur_pkg::CH_W-1:0]            o_out_green,
    output logic [bblur_pkg::CH_W-1:0]            o_out_blue,
    output logic                                  o_end_of_frame
);
    localparam int CH_W   = bblur_pkg::CH_W;
    localparam int PIX_W  = bblur_pkg::PIX_W;
    localparam int COL_W  = bblur_pkg::COL_W;
    localparam int LEAD_W = bblur_pkg::LEAD_W;
    localparam int ROW_W  = bblur_pkg::ROW_W;
    localparam int IROW_W = bblur_pkg::IROW_W;
    localparam int HGT_W  = bblur_pkg::HGT_W;
    localparam int WID_W  = bblur_pkg::WID_W;
    localparam int CSUM_W = bblur_pkg::CSUM_W;
    localparam int SUM_W  = bblur_pkg::SUM_W;
    localparam int NUM_W  = bblur_pkg::NUM_W;
    localparam int CNT_W  = bblur_pkg::CNT_W;
    localparam int DEN_W  = bblur_pkg::DEN_W;

    // configuration and frame state
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [LEAD_W-1:0] r_lead,    n_lead;
    logic              r_all_in,  n_all_in;
    logic [PIX_W-1:0]  r_win [6];
    logic [PIX_W-1:0]  n_win [6];

    // item in flight
    logic [PIX_W-1:0]  r_pix;
    logic [COL_W-1:0]  r_ic;
    logic [CSUM_W-1:0] r_csum [3][3];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;
    logic [NUM_W-1:0]  r_num [3];
    logic [DEN_W-1:0]  r_rem [3];
    logic [DEN_W-1:0]  r_den;

    // output register
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch [3];
    logic              r_out_eof;

    logic [LEAD_W-1:0] w_width;
    logic [HGT_W-1:0]  w_height;
    logic [COL_W-1:0]  w_ic;
    logic [PIX_W-1:0]  w_rd_upper, w_rd_middle;
    logic              w_mem_we;
    logic [PIX_W-1:0]  w_col [3][3];
    logic [2:0]        w_col_ok, w_row_ok;
    logic [CSUM_W-1:0] w_csum [3][3];
    logic [1:0]        w_cc, w_rc;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_emit, w_last, w_restart;
    logic [LEAD_W-1:0] w_ic_next;

    // effective frame size, out-of-range values clamped
    always_comb begin
        if (r_width == '0) begin
            w_width = LEAD_W'(1);
        end else if (int'(r_width) > bblur_pkg::MAX_WIDTH) begin
            w_width = LEAD_W'(bblur_pkg::MAX_WIDTH);
        end else begin
            w_width = LEAD_W'(r_width);
        end
        if (r_height == '0) begin
            w_height = HGT_W'(1);
        end else if (int'(r_height) > bblur_pkg::HEIGHT_LIMIT) begin
            w_height = HGT_W'(bblur_pkg::HEIGHT_LIMIT);
        end else begin
            w_height = r_height;
        end
    end

    assign w_ic = (LEAD_W'(r_in_col) >= w_width) ? '0 : r_in_col;

    assign w_mem_we = i_cmd.process && !r_all_in;

    bblur_ram #(.WIDTH(PIX_W), .DEPTH(bblur_pkg::MAX_WIDTH)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_ic),
        .i_wdata (w_rd_middle),
        .i_raddr (w_ic),
        .o_rdata (w_rd_upper)
    );

    bblur_ram #(.WIDTH(PIX_W), .DEPTH(bblur_pkg::MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_ic),
        .i_wdata (r_pix),
        .i_raddr (w_ic),
        .o_rdata (w_rd_middle)
    );

    // window columns: left, centre, and the new column from the line stores
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_col[0][r] = r_win[r];
            w_col[1][r] = r_win[3 + r];
        end
        w_col[2][0] = w_rd_upper;
        w_col[2][1] = w_rd_middle;
        w_col[2][2] = r_all_in ? '0 : r_pix;
    end

    assign w_col_ok[0] = (r_out_col != '0);
    assign w_col_ok[1] = 1'b1;
    assign w_col_ok[2] = (LEAD_W'(r_out_col) + LEAD_W'(1)) < w_width;
    assign w_row_ok[0] = (r_out_row != '0);
    assign w_row_ok[1] = 1'b1;
    assign w_row_ok[2] = (HGT_W'(r_out_row) + HGT_W'(1)) < w_height;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
                w_csum[k][ch] = '0;
                for (int j = 0; j < 3; j++) begin
                    if (w_col_ok[k] && w_row_ok[j]) begin
                        w_csum[k][ch] = w_csum[k][ch]
                                      + CSUM_W'(w_col[k][j][(2 - ch) * CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    assign w_cc   = 2'd1 + 2'(w_col_ok[0]) + 2'(w_col_ok[2]);
    assign w_rc   = 2'd1 + 2'(w_row_ok[0]) + 2'(w_row_ok[2]);
    assign w_cnt  = CNT_W'(w_cc) * CNT_W'(w_rc);
    assign w_emit = (r_lead >= (w_width + LEAD_W'(1)));
    assign w_last = !w_row_ok[2] && !w_col_ok[2];
    assign w_ic_next = LEAD_W'(r_ic) + LEAD_W'(1);
    assign w_restart = i_cfg_we || (i_cmd.process && w_emit && w_last);

    // frame state update
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        n_all_in  = r_all_in;
        n_win     = r_win;
        if (i_cmd.process) begin
            if (w_ic_next >= w_width) begin
                n_in_col = '0;
                if (!r_all_in) begin
                    n_in_row = r_in_row + 1'b1;
                    if ((HGT_W'(r_in_row) + HGT_W'(1)) >= w_height) begin
                        n_all_in = 1'b1;
                    end
                end
            end else begin
                n_in_col = w_ic_next[COL_W-1:0];
            end
            for (int r = 0; r < 3; r++) begin
                n_win[r]     = r_win[3 + r];
                n_win[3 + r] = w_col[2][r];
            end
            if (!w_emit) begin
                n_lead = r_lead + 1'b1;
            end else if (!w_col_ok[2]) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (w_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
            n_all_in  = 1'b0;
            for (int r = 0; r < 6; r++) begin
                n_win[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(bblur_pkg::WIDTH_RESET);
            r_height  <= HGT_W'(bblur_pkg::HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
            r_all_in  <= 1'b0;
            for (int r = 0; r < 6; r++) begin
                r_win[r] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (bblur_pkg::t_cfg_reg'(i_cfg_idx))
                    bblur_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    bblur_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                    default: begin
                        r_width <= r_width;
                    end
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
            r_all_in  <= n_all_in;
            r_win     <= n_win;
        end
    end

    // item payload, sums and divider: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= {i_red, i_green, i_blue};
            r_ic  <= w_ic;
        end
        if (i_cmd.process && w_emit) begin
            r_csum <= w_csum;
            r_cnt  <= w_cnt;
            r_last <= w_last;
        end
        if (i_cmd.sum_load) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_num[ch] <= {SUM_W'(r_csum[0][ch]) + SUM_W'(r_csum[1][ch])
                              + SUM_W'(r_csum[2][ch]), 1'b0} + NUM_W'(r_cnt);
                r_rem[ch] <= '0;
            end
            r_den <= {r_cnt, 1'b0};
        end else if (i_cmd.div_step) begin
            // one restoring step per channel; quotient bits shift into r_num
            for (int ch = 0; ch < 3; ch++) begin
                if ({r_rem[ch], r_num[ch][NUM_W-1]} >= {1'b0, r_den}) begin
                    r_rem[ch] <= DEN_W'({r_rem[ch], r_num[ch][NUM_W-1]} - {1'b0, r_den});
                    r_num[ch] <= {r_num[ch][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= {r_rem[ch][DEN_W-2:0], r_num[ch][NUM_W-1]};
                    r_num[ch] <= {r_num[ch][NUM_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.out_load) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_ch[ch] <= r_num[ch][CH_W-1:0];
            end
            r_out_eof <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.drop     = i_opcode && !r_all_in;
    assign o_sts.emit     = w_emit;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_ch[0];
    assign o_out_green    = r_out_ch[1];
    assign o_out_blue     = r_out_ch[2];
    assign o_end_of_frame = r_out_eof;
endmodule

// File: bench/tb_box_blur_3x3_edge_aware.sv
// Self-checking bench for the 3x3 edge-aware box blur: a planned stream of frames,
// register writes and pauses feeds a clocked driver, a monitor checks every result.
// Depends on bblur_pkg, bblur_in_if, bblur_out_if and box_blur_3x3_edge_aware.
module tb_box_blur_3x3_edge_aware;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   PIX_W         = bblur_pkg::PIX_W;
    localparam int   CH_W          = bblur_pkg::CH_W;
    localparam int   WID_W         = bblur_pkg::WID_W;
    localparam int   HGT_W         = bblur_pkg::HGT_W;
    localparam int   MAX_WIDTH     = bblur_pkg::MAX_WIDTH;
    localparam int   HEIGHT_LIMIT  = bblur_pkg::HEIGHT_LIMIT;
    localparam int   CFG_DATA_W    = bblur_pkg::CFG_DATA_W;
    localparam logic OP_PIXEL      = 1'b0;
    localparam logic OP_DRAIN      = 1'b1;
    localparam int   PAT_RANDOM    = 0;
    localparam int   PAT_EXTREME   = 1;
    localparam int   SETTLE_CYCLES = 20;
    localparam int   STALL_LIMIT   = 3000;

    typedef enum logic [1:0] {
        STEP_SEND,
        STEP_WRITE,
        STEP_SETTLE,
        STEP_MODE
    } t_step_kind;

    typedef struct {
        t_step_kind          kind;
        logic                opcode;
        logic [PIX_W-1:0]    pix;
        bblur_pkg::t_cfg_reg idx;
        logic [12:0]         data;
        int                  idle_pct;
        int                  stall_pct;
    } t_step;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            eof;
    } t_blur_px;

    logic     i_clk;
    logic     i_rst_n;
    logic     cfg_we;
    bblur_pkg::t_cfg_reg cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bblur_in_if  pix_if ();
    bblur_out_if res_if ();

    box_blur_3x3_edge_aware u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Stimulus plan and expected blurred pixels
    t_step    plan_q [$];
    t_blur_px blurred_q [$];

    // Predictor state
    bit [PIX_W-1:0]  upper_row [MAX_WIDTH];
    bit [PIX_W-1:0]  middle_row [MAX_WIDTH];
    bit [PIX_W-1:0]  left_col [3];
    bit [PIX_W-1:0]  centre_col [3];
    int unsigned     pix_col, pix_row, blur_col, blur_row, lead_cnt;
    bit              frame_in;
    logic [WID_W-1:0] width_reg  = WID_W'(bblur_pkg::WIDTH_RESET);
    logic [HGT_W-1:0] height_reg = HGT_W'(bblur_pkg::HEIGHT_RESET);

    // Run bookkeeping
    int unsigned n_predicted, n_checked, n_taken, n_writes, n_frames;
    int          fault_cnt, send_idle_pct, stall_pct, settle_left, quiet_cycles;
    logic        stim_done;

    function automatic int unsigned clamp_width(input logic [WID_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > MAX_WIDTH) ? MAX_WIDTH : v;
    endfunction

    function automatic int unsigned clamp_height(input logic [HGT_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
    endfunction

    function automatic void frame_restart();
        left_col   = '{default: '0};
        centre_col = '{default: '0};
        pix_col    = 0;
        pix_row    = 0;
        blur_col   = 0;
        blur_row   = 0;
        lead_cnt   = 0;
        frame_in   = 1'b0;
    endfunction

    // Advance the blur model by one accepted transfer; queue the blurred pixel it yields.
    function automatic void blur_predict(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned w, h, ic, cnt, n_cols, n_rows, k, j;
        int unsigned acc [3];
        bit [PIX_W-1:0] fresh [3];
        bit [PIX_W-1:0] cols [3][3];
        bit col_ok [3];
        bit row_ok [3];
        bit eof;
        t_blur_px px;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        // drain before the whole frame is in: no effect at all
        if (op == OP_DRAIN && !frame_in)
            return;
        ic = (pix_col >= w) ? 0 : pix_col;
        fresh[0] = upper_row[ic];
        fresh[1] = middle_row[ic];
        fresh[2] = frame_in ? '0 : pix;
        if (!frame_in) begin
            upper_row[ic]  = middle_row[ic];
            middle_row[ic] = pix;
        end
        ic++;
        if (ic >= w) begin
            ic = 0;
            if (!frame_in) begin
                pix_row++;
                if (pix_row >= h)
                    frame_in = 1'b1;
            end
        end
        pix_col = ic;
        if (lead_cnt < w + 1) begin
            lead_cnt++;
            left_col   = centre_col;
            centre_col = fresh;
            return;
        end
        cols[0] = left_col;
        cols[1] = centre_col;
        cols[2] = fresh;
        col_ok  = '{blur_col > 0, 1'b1, blur_col + 1 < w};
        row_ok  = '{blur_row > 0, 1'b1, blur_row + 1 < h};
        n_cols  = 0;
        n_rows  = 0;
        acc     = '{0, 0, 0};
        for (k = 0; k < 3; k++) begin
            n_cols += col_ok[k];
            n_rows += row_ok[k];
        end
        // mask out-of-frame neighbours
        for (k = 0; k < 3; k++)
            for (j = 0; j < 3; j++)
                if (col_ok[k] && row_ok[j]) begin
                    acc[0] += cols[k][j][23:16];
                    acc[1] += cols[k][j][15:8];
                    acc[2] += cols[k][j][7:0];
                end
        cnt      = n_cols * n_rows;
        eof      = (blur_row + 1 >= h) && (blur_col + 1 >= w);
        px.red   = CH_W'((2 * acc[0] + cnt) / (2 * cnt));
        px.green = CH_W'((2 * acc[1] + cnt) / (2 * cnt));
        px.blue  = CH_W'((2 * acc[2] + cnt) / (2 * cnt));
        px.eof   = eof;
        blurred_q.push_back(px);
        n_predicted++;
        left_col   = centre_col;
        centre_col = fresh;
        if (eof) begin
            frame_restart();
        end else begin
            blur_col++;
            if (blur_col >= w) begin
                blur_col = 0;
                blur_row++;
            end
        end
    endfunction

    function automatic void plan_step(input t_step_kind kind, input logic op,
                                      input logic [PIX_W-1:0] pix,
                                      input bblur_pkg::t_cfg_reg idx,
                                      input logic [12:0] data, input int idle, input int stall);
        t_step s;
        s.kind      = kind;
        s.opcode    = op;
        s.pix       = pix;
        s.idx       = idx;
        s.data      = data;
        s.idle_pct  = idle;
        s.stall_pct = stall;
        plan_q.push_back(s);
    endfunction

    function automatic void plan_item(input logic op, input logic [PIX_W-1:0] pix);
        plan_step(STEP_SEND, op, pix, bblur_pkg::CFG_FRAME_WIDTH, '0, 0, 0);
    endfunction

    // Writes only go in once the block has gone quiet
    function automatic void plan_write(input bblur_pkg::t_cfg_reg idx, input logic [12:0] data);
        plan_step(STEP_SETTLE, OP_PIXEL, '0, bblur_pkg::CFG_FRAME_WIDTH, '0, 0, 0);
        plan_step(STEP_WRITE, OP_PIXEL, '0, idx, data, 0, 0);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int pattern);
        logic [2:0] b;
        if (pattern != PAT_EXTREME)
            return PIX_W'($urandom);
        b = 3'($urandom);
        return {{CH_W{b[2]}}, {CH_W{b[1]}}, {CH_W{b[0]}}};
    endfunction

    // One frame: optional register writes, pixels with stray early drains, then the flush.
    // A cut frame stops part way; the next frame must rewrite the registers.
    function automatic void plan_frame(input logic [12:0] w_data, input logic [12:0] h_data,
                                       input bit rewrite, input int pattern, input bit cut);
        int unsigned w, h, npix, pause_at, i;
        logic op;
        w        = clamp_width(w_data[WID_W-1:0]);
        h        = clamp_height(h_data);
        npix     = cut ? $urandom_range(w * h - 1, 0) : w * h;
        pause_at = $urandom_range(3 * npix, 0);
        if (rewrite) begin
            plan_write(bblur_pkg::CFG_FRAME_WIDTH, w_data);
            plan_write(bblur_pkg::CFG_FRAME_HEIGHT, h_data);
        end
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(99) < 4)
                plan_item(OP_DRAIN, pick_pixel(PAT_RANDOM));
            if (i == pause_at)
                plan_step(STEP_SETTLE, OP_PIXEL, '0, bblur_pkg::CFG_FRAME_WIDTH, '0, 0, 0);
            plan_item(OP_PIXEL, pick_pixel(pattern));
        end
        if (!cut)
            for (i = 0; i <= w; i++) begin
                // surplus pixels flush like drains
                op = ($urandom_range(99) < 15) ? OP_PIXEL : OP_DRAIN;
                plan_item(op, pick_pixel(PAT_RANDOM));
            end
    endfunction

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Driver: one plan step at a time, predicting on every accepted transfer
    always @(posedge i_clk) begin
        t_step head;
        logic  send;
        logic  we_nxt;
        send   = 1'b0;
        we_nxt = 1'b0;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            cfg_we       <= 1'b0;
            stim_done    <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                blur_predict(pix_if.opcode, {pix_if.in_red, pix_if.in_green, pix_if.in_blue});
                n_taken++;
            end
            if (pix_if.valid && !pix_if.ready) begin
                send = 1'b1;
            end else if (settle_left != 0) begin
                settle_left--;
            end else if (plan_q.size() != 0) begin
                head = plan_q[0];
                case (head.kind)
                    STEP_MODE: begin
                        send_idle_pct = head.idle_pct;
                        stall_pct    <= head.stall_pct;
                        void'(plan_q.pop_front());
                    end
                    STEP_SETTLE: begin
                        if (n_checked == n_predicted) begin
                            settle_left = SETTLE_CYCLES;
                            void'(plan_q.pop_front());
                        end
                    end
                    STEP_WRITE: begin
                        we_nxt    = 1'b1;
                        cfg_idx  <= head.idx;
                        cfg_data <= head.data;
                        case (head.idx)
                            bblur_pkg::CFG_FRAME_WIDTH:  width_reg  = head.data[WID_W-1:0];
                            bblur_pkg::CFG_FRAME_HEIGHT: height_reg = head.data[HGT_W-1:0];
                            default: ;
                        endcase
                        frame_restart();
                        n_writes++;
                        void'(plan_q.pop_front());
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            send             = 1'b1;
                            pix_if.opcode   <= head.opcode;
                            pix_if.in_red   <= head.pix[23:16];
                            pix_if.in_green <= head.pix[15:8];
                            pix_if.in_blue  <= head.pix[7:0];
                            void'(plan_q.pop_front());
                        end
                    end
                endcase
            end
            pix_if.valid <= send;
            cfg_we       <= we_nxt;
            stim_done    <= (plan_q.size() == 0) && !send && (settle_left == 0);
        end
    end

    // Monitor: compare each transfer with the oldest expected pixel
    always @(posedge i_clk) begin
        t_blur_px want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (blurred_q.size() == 0) begin
                    $error("unexpected result: red %0d green %0d blue %0d end_of_frame %0d",
                           res_if.out_red, res_if.out_green, res_if.out_blue,
                           res_if.end_of_frame);
                    fault_cnt++;
                end else begin
                    want = blurred_q.pop_front();
                    if (res_if.out_red !== want.red) begin
                        $error("out_red: expected %0d, got %0d", want.red, res_if.out_red);
                        fault_cnt++;
                    end
                    if (res_if.out_green !== want.green) begin
                        $error("out_green: expected %0d, got %0d", want.green, res_if.out_green);
                        fault_cnt++;
                    end
                    if (res_if.out_blue !== want.blue) begin
                        $error("out_blue: expected %0d, got %0d", want.blue, res_if.out_blue);
                        fault_cnt++;
                    end
                    if (res_if.end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %0d, got %0d",
                               want.eof, res_if.end_of_frame);
                        fault_cnt++;
                    end
                    if (want.eof)
                        n_frames++;
                    n_checked <= n_checked + 1;
                end
            end
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up after a long stretch without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, n_predicted - n_checked);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        logic [PIX_W-1:0] corner_mix [9];
        logic [12:0] w_data, h_data;
        int idle_of [4];
        int stall_of [4];
        int budget, ph, i;
        bit rewrite, cut;

        i_rst_n          = 1'b0;
        pix_if.valid     = 1'b0;
        pix_if.opcode    = OP_PIXEL;
        pix_if.in_red    = '0;
        pix_if.in_green  = '0;
        pix_if.in_blue   = '0;
        res_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = bblur_pkg::CFG_FRAME_WIDTH;
        cfg_data         = '0;
        stim_done        = 1'b0;
        quiet_cycles     = 0;
        n_checked        = 0;
        stall_pct        = 0;
        send_idle_pct    = 0;
        corner_mix = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
                       24'h000000, 24'h0100FF, 24'hFE01FE, 24'h807F80};
        idle_of  = '{0, 75, 0, 25};
        stall_of = '{0, 0, 75, 25};

        // Directed: 3x3 frame of extremes, masked upper width bits, early drain,
        // mid-frame hold-off and a surplus pixel among the flush
        plan_step(STEP_MODE, OP_PIXEL, '0, bblur_pkg::CFG_FRAME_WIDTH, '0, 25, 25);
        plan_write(bblur_pkg::CFG_FRAME_WIDTH, 13'h1803);
        plan_write(bblur_pkg::CFG_FRAME_HEIGHT, 13'd3);
        plan_item(OP_DRAIN, 24'h123456);
        for (i = 0; i < 9; i++) begin
            plan_item(OP_PIXEL, corner_mix[i]);
            if (i == 4)
                plan_step(STEP_SETTLE, OP_PIXEL, '0, bblur_pkg::CFG_FRAME_WIDTH, '0, 0, 0);
        end
        plan_item(OP_DRAIN, 24'h000000);
        plan_item(OP_PIXEL, 24'hFFFFFF);
        plan_item(OP_DRAIN, 24'hFFFFFF);
        plan_item(OP_DRAIN, 24'h000000);
        // zero sizes act as one; abandoned frame; frames back to back without a write
        plan_frame(13'd0, 13'd0, 1'b1, PAT_EXTREME, 1'b0);
        plan_frame(13'd4, 13'd2, 1'b1, PAT_EXTREME, 1'b1);
        plan_frame(13'd1, 13'd2, 1'b1, PAT_RANDOM, 1'b0);
        plan_frame(13'd1, 13'd2, 1'b0, PAT_RANDOM, 1'b0);

        // Random frames, one batch per idling mode
        w_data = '0;
        h_data = '0;
        for (ph = 0; ph < 4; ph++) begin
            plan_step(STEP_MODE, OP_PIXEL, '0, bblur_pkg::CFG_FRAME_WIDTH, '0,
                      idle_of[ph], stall_of[ph]);
            budget = 0;
            cut    = 1'b1;
            while (budget < 110) begin
                rewrite = cut || ($urandom_range(9) < 7);
                if (rewrite) begin
                    if ($urandom_range(3) == 0) begin
                        w_data = {2'($urandom), 11'($urandom_range(40, 7))};
                        h_data = 13'($urandom_range(4, 1));
                    end else begin
                        w_data = {2'($urandom), 11'($urandom_range(6, 1))};
                        h_data = 13'($urandom_range(8, 1));
                    end
                end
                cut = ($urandom_range(9) == 0);
                plan_frame(w_data, h_data, rewrite,
                           ($urandom_range(3) == 0) ? PAT_EXTREME : PAT_RANDOM, cut);
                budget += w_data[WID_W-1:0] * h_data + w_data[WID_W-1:0] + 1;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (!stim_done || n_checked != n_predicted);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Box blur run: %0d transfers in, %0d blurred pixels checked, %0d frames ended,",
                 n_taken, n_checked, n_frames);
        $display("  %0d register writes, sizes 1x1 up to 40 wide and 8 high, stalls both sides.",
                 n_writes);
        if (fault_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
